/* rtl/bdphr_pkg.sv */
package bdphr_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int CMP_WIDTH   = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  localparam int DEB_WIDTH  = 8;
  localparam int HOLD_WIDTH = 16;
  localparam int CFG_WIDTH  = 16;
  localparam int IDX_WIDTH  = 2;

  localparam logic [DEB_WIDTH-1:0]  DEB_RESET  = 8'd20;
  localparam logic [HOLD_WIDTH-1:0] HOLD_RESET = 16'd1000;

  localparam logic [IDX_WIDTH-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_HOLD     = 2'd1;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_HOLD    = 2'd2;
  localparam logic [1:0] EV_RELEASE = 2'd3;

  typedef struct packed {
    logic [DEB_WIDTH-1:0]  debounce_ticks;
    logic [HOLD_WIDTH-1:0] hold_ticks;
  } cfg_t;

  function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] v);
    sat_inc = (v == TIMER_MAX) ? TIMER_MAX : v + TIMER_WIDTH'(1);
  endfunction

endpackage

/* rtl/bdphr_cfg.sv */
module bdphr_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_en,
  input  logic [bdphr_pkg::IDX_WIDTH-1:0]    cfg_index,
  input  logic [bdphr_pkg::CFG_WIDTH-1:0]    cfg_data,
  output bdphr_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= bdphr_pkg::DEB_RESET;
      cfg.hold_ticks     <= bdphr_pkg::HOLD_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        bdphr_pkg::REG_DEBOUNCE: begin
          cfg.debounce_ticks <= cfg_data[bdphr_pkg::DEB_WIDTH-1:0];
        end
        bdphr_pkg::REG_HOLD: begin
          cfg.hold_ticks <= cfg_data[bdphr_pkg::HOLD_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/bdphr_core.sv */
module bdphr_core (
  input  logic            clk,
  input  logic            rst,
  input  bdphr_pkg::cfg_t cfg,
  input  logic            commit,
  input  logic            level,
  output logic [1:0]      ev
);

  logic                              raw_previous;
  logic                              stable_previous;
  logic [bdphr_pkg::TIMER_WIDTH-1:0] quiet_ticks;
  logic [bdphr_pkg::TIMER_WIDTH-1:0] press_ticks;
  logic                              awaiting_release;

  logic [bdphr_pkg::TIMER_WIDTH-1:0] quiet_ticks_next;
  logic [bdphr_pkg::TIMER_WIDTH-1:0] press_ticks_next;
  logic                              stable_previous_next;
  logic                              awaiting_release_next;
  logic [bdphr_pkg::CMP_WIDTH-1:0]   press_cmp;
  logic [bdphr_pkg::CMP_WIDTH-1:0]   hold_cmp;
  logic                              stable;

  always_comb begin
    quiet_ticks_next      = (level != raw_previous) ? '0 : bdphr_pkg::sat_inc(quiet_ticks);
    press_ticks_next      = bdphr_pkg::sat_inc(press_ticks);
    stable_previous_next  = stable_previous;
    awaiting_release_next = awaiting_release;
    ev                    = bdphr_pkg::EV_NONE;
    press_cmp = bdphr_pkg::CMP_WIDTH'(press_ticks_next);
    hold_cmp  = bdphr_pkg::CMP_WIDTH'(cfg.hold_ticks);
    // debounce is 8 bits, timer at least 9, so zero-extend and compare
    stable    = quiet_ticks_next >
                bdphr_pkg::TIMER_WIDTH'(cfg.debounce_ticks);
    if (stable) begin
      if (!level && stable_previous) begin
        press_ticks_next      = '0;
        awaiting_release_next = 1'b1;
        stable_previous_next  = 1'b0;
        ev                    = bdphr_pkg::EV_PRESS;
      end else if (awaiting_release && (press_cmp >= hold_cmp)) begin
        awaiting_release_next = 1'b0;
        ev                    = bdphr_pkg::EV_HOLD;
      end else if (level && !stable_previous) begin
        // release after a hold is swallowed
        if (awaiting_release) begin
          awaiting_release_next = 1'b0;
          ev                    = bdphr_pkg::EV_RELEASE;
        end
        stable_previous_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_previous     <= 1'b1;
      stable_previous  <= 1'b1;
      quiet_ticks      <= '0;
      press_ticks      <= '0;
      awaiting_release <= 1'b0;
    end else if (commit) begin
      raw_previous     <= level;
      stable_previous  <= stable_previous_next;
      quiet_ticks      <= quiet_ticks_next;
      press_ticks      <= press_ticks_next;
      awaiting_release <= awaiting_release_next;
    end
  end

endmodule

/* rtl/button_debounce_press_hold_release.sv */
// Path: a request accepted into the input register moves into the result
// register once that register is free, and can be taken from there.
// Throughput: one tick per clock; the input register keeps taking requests
// while a result waits, and stalls only when both stages are full.
// Reset: rst is synchronous, active high; clears both stages, the debounce
// state and the counters, and loads debounce_ticks 20 and hold_ticks 1000.
module button_debounce_press_hold_release (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            pin_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      event_code,
  input  logic                            cfg_write_en,
  input  logic [bdphr_pkg::IDX_WIDTH-1:0] cfg_index,
  input  logic [bdphr_pkg::CFG_WIDTH-1:0] cfg_data
);

  bdphr_pkg::cfg_t cfg;
  logic            s1_valid;
  logic            s1_level;
  logic            advance;
  logic [1:0]      ev;

  // result register is free when empty or being taken this cycle
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  bdphr_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  bdphr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .commit (advance),
    .level  (s1_level),
    .ev     (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_level <= pin_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_code <= ev;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled while result register could take a request");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced request did not reach result register");

  a_stage_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> (s1_valid && $stable(s1_level)))
    else $error("input stage lost a request while stalled");
`endif

endmodule

/* verif/button_debounce_press_hold_release_test.sv */
`timescale 1ns / 100ps

module button_debounce_press_hold_release_test;

  localparam int LATENCY        = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int LONG_HOLD_OFF  = 200;

  // indexes the block does not decode
  localparam logic [bdphr_pkg::IDX_WIDTH-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [bdphr_pkg::IDX_WIDTH-1:0] REG_SPARE_3 = 2'd3;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic                            pin_level;
  logic                            out_valid;
  logic                            out_stall;
  logic [1:0]                      event_code;
  logic                            cfg_write_en;
  logic [bdphr_pkg::IDX_WIDTH-1:0] cfg_index;
  logic [bdphr_pkg::CFG_WIDTH-1:0] cfg_data;

  // predictor state
  logic [bdphr_pkg::DEB_WIDTH-1:0]   deb_limit;
  logic [bdphr_pkg::HOLD_WIDTH-1:0]  hold_limit;
  logic                              pin_prev;
  logic                              level_stable;
  logic                              level_stable_prev;
  logic [bdphr_pkg::TIMER_WIDTH-1:0] quiet_count;
  logic [bdphr_pkg::TIMER_WIDTH-1:0] press_count;
  logic                              hold_pending;

  logic [1:0] expected_events[$];

  int in_idle_pct;
  int out_stall_pct;
  int hold_off_req;
  int hold_off_left;
  int idle_cycles;
  int ticks_sent;
  int results_checked;
  int error_count;
  int press_seen;
  int hold_seen;
  int release_seen;

  button_debounce_press_hold_release i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pin_level    (pin_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_code   (event_code),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [1:0] debounce_tick(input logic lvl);
    logic [1:0] ev;
    ev = bdphr_pkg::EV_NONE;
    if (lvl != pin_prev) begin
      quiet_count = '0;
    end else if (quiet_count != bdphr_pkg::TIMER_MAX) begin
      quiet_count = quiet_count + bdphr_pkg::TIMER_WIDTH'(1);
    end
    if (press_count != bdphr_pkg::TIMER_MAX) begin
      press_count = press_count + bdphr_pkg::TIMER_WIDTH'(1);
    end
    if (32'(quiet_count) > 32'(deb_limit)) begin
      level_stable = lvl;
      if (!level_stable && level_stable_prev) begin
        press_count       = '0;
        hold_pending      = 1'b1;
        level_stable_prev = 1'b0;
        ev                = bdphr_pkg::EV_PRESS;
      end else if (hold_pending && 32'(press_count) >= 32'(hold_limit)) begin
        hold_pending = 1'b0;
        ev           = bdphr_pkg::EV_HOLD;
      end else if (level_stable && !level_stable_prev) begin
        // release only counts when no hold was reported for this press
        if (hold_pending) begin
          hold_pending = 1'b0;
          ev           = bdphr_pkg::EV_RELEASE;
        end
        level_stable_prev = 1'b1;
      end
    end
    pin_prev = lvl;
    return ev;
  endfunction

  // entered and left at a falling edge; valid stays up on return
  task automatic send_tick(input logic lvl);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    pin_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_events.push_back(debounce_tick(lvl));
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bdphr_pkg::IDX_WIDTH-1:0] idx,
                           input logic [bdphr_pkg::CFG_WIDTH-1:0] data);
    drain_results();
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      bdphr_pkg::REG_DEBOUNCE: deb_limit = data[bdphr_pkg::DEB_WIDTH-1:0];
      bdphr_pkg::REG_HOLD:     hold_limit = data[bdphr_pkg::HOLD_WIDTH-1:0];
      default: ;
    endcase
  endtask

  // mostly clean press/release cycles with a little bounce, some pure noise
  task automatic run_random_phase(input int n);
    int start;
    int low_len;
    int high_len;
    start = ticks_sent;
    while (ticks_sent - start < n) begin
      if ($urandom_range(9) < 8) begin
        repeat ($urandom_range(3)) send_tick(1'($urandom_range(1)));
        low_len = deb_limit + $urandom_range((hold_limit < 40) ? hold_limit + 4 : 40);
        repeat (low_len) send_tick(1'b0);
        repeat ($urandom_range(3)) send_tick(1'($urandom_range(1)));
        high_len = deb_limit + $urandom_range(6);
        repeat (high_len) send_tick(1'b1);
      end else begin
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_default_settings();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    run_random_phase(60);
  endtask

  task automatic test_directed();
    write_reg(bdphr_pkg::REG_DEBOUNCE, 16'h0000);
    write_reg(bdphr_pkg::REG_HOLD, 16'h0000);
    write_reg(REG_SPARE_2, 16'hFFFF);
    write_reg(REG_SPARE_3, 16'h5A5A);
    // zero hold: hold right after the press, release then suppressed
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    // bounce never settles
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    write_reg(bdphr_pkg::REG_HOLD, 16'h0002);
    // short press still reaches the hold limit of 2, so it gets a hold, no release
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    // long low stretch gets no press: the stable level stayed low after the hold
    repeat (6) send_tick(1'b0);
    repeat (3) send_tick(1'b1);
  endtask

  // largest debounce delay, then a fast release
  task automatic test_debounce_extreme();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    write_reg(bdphr_pkg::REG_DEBOUNCE, 16'h5AFF);
    write_reg(bdphr_pkg::REG_HOLD, 16'd300);
    repeat (260) send_tick(1'b0);
    write_reg(bdphr_pkg::REG_DEBOUNCE, 16'h0000);
    repeat (3) send_tick(1'b1);
  endtask

  task automatic test_random_traffic();
    int in_pcts[4];
    int out_pcts[4];
    in_pcts  = '{0, 88, 0, 29};
    out_pcts = '{0, 0, 88, 29};
    for (int p = 0; p < 4; p++) begin
      write_reg(bdphr_pkg::REG_DEBOUNCE,
                {8'($urandom_range(255)), 8'((p == 0) ? 0 : $urandom_range(5))});
      write_reg(bdphr_pkg::REG_HOLD, 16'($urandom_range(40)));
      in_idle_pct   = in_pcts[p];
      out_stall_pct = out_pcts[p];
      run_random_phase(40);
    end
  endtask

  task automatic test_backpressure();
    drain_results();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    @(posedge clk);
    hold_off_req = LONG_HOLD_OFF;
    @(negedge clk);
    repeat (20) send_tick(1'b0);
    repeat (20) send_tick(1'b1);
    drain_results();
    in_idle_pct   = 29;
    out_stall_pct = 29;
    run_random_phase(40);
  endtask

  always @(negedge clk) begin
    if (hold_off_left == 0 && hold_off_req != 0) begin
      hold_off_left = hold_off_req;
      hold_off_req  = 0;
    end
    if (hold_off_left != 0) begin
      out_stall <= 1'b1;
      hold_off_left--;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin
    logic [1:0] exp_ev;
    if (!rst && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("Unexpected event %0d with no request outstanding", event_code);
      end else begin
        exp_ev = expected_events.pop_front();
        results_checked++;
        if (event_code !== exp_ev) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("Event mismatch on result %0d: expected %0d, got %0d",
                     results_checked, exp_ev, event_code);
        end else begin
          case (exp_ev)
            bdphr_pkg::EV_PRESS:   press_seen++;
            bdphr_pkg::EV_HOLD:    hold_seen++;
            bdphr_pkg::EV_RELEASE: release_seen++;
            default: ;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    pin_level     = 1'b1;
    out_stall     = 1'b0;
    cfg_write_en  = 1'b0;
    cfg_index     = bdphr_pkg::REG_DEBOUNCE;
    cfg_data      = '0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_off_req  = 0;
    hold_off_left = 0;
    idle_cycles   = 0;
    ticks_sent    = 0;
    results_checked = 0;
    error_count   = 0;
    press_seen    = 0;
    hold_seen     = 0;
    release_seen  = 0;

    deb_limit         = bdphr_pkg::DEB_RESET;
    hold_limit        = bdphr_pkg::HOLD_RESET;
    pin_prev          = 1'b1;
    level_stable      = 1'b1;
    level_stable_prev = 1'b1;
    quiet_count       = '0;
    press_count       = '0;
    hold_pending      = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_settings();
    test_directed();
    test_debounce_extreme();
    test_random_traffic();
    test_backpressure();
    drain_results();

    if (expected_events.size() != 0) begin
      error_count += expected_events.size();
      $display("%0d expected events never arrived", expected_events.size());
    end
    $display("Checked %0d ticks: %0d presses, %0d holds, %0d releases.",
             results_checked, press_seen, hold_seen, release_seen);
    $display("Debounce 0..255 with junk upper write bits, short and zero hold times,");
    $display("idle and stall phases on both sides and a long output hold-off.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
